// ===== design/smpsa_pkg.sv =====
package smpsa_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 32;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int STEP_W      = 4;
   localparam int OP_W        = 4;
   localparam int COND_W      = 3;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 40;

   localparam logic [KIND_W-1:0] K_PUSH  = 3'd0;
   localparam logic [KIND_W-1:0] K_PRINT = 3'd1;
   localparam logic [KIND_W-1:0] K_SWAP  = 3'd2;
   localparam logic [KIND_W-1:0] K_ADD   = 3'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SWAP_UNDER = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ADD_UNDER  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

   localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
   localparam logic [OP_W-1:0] OP_FETCH      = 4'd1;
   localparam logic [OP_W-1:0] OP_PUSH       = 4'd2;
   localparam logic [OP_W-1:0] OP_READ2      = 4'd3;
   localparam logic [OP_W-1:0] OP_SWAP_TOP   = 4'd4;
   localparam logic [OP_W-1:0] OP_SWAP_BELOW = 4'd5;
   localparam logic [OP_W-1:0] OP_ADD        = 4'd6;
   localparam logic [OP_W-1:0] OP_PRINT_RD   = 4'd7;
   localparam logic [OP_W-1:0] OP_EMIT       = 4'd8;
   localparam logic [OP_W-1:0] OP_RESP       = 4'd9;

   localparam logic [COND_W-1:0] C_ALWAYS   = 3'd0;
   localparam logic [COND_W-1:0] C_DISPATCH = 3'd1;
   localparam logic [COND_W-1:0] C_FULL     = 3'd2;
   localparam logic [COND_W-1:0] C_LT2      = 3'd3;
   localparam logic [COND_W-1:0] C_EMPTY    = 3'd4;
   localparam logic [COND_W-1:0] C_IDX_NZ   = 3'd5;

   localparam logic [STEP_W-1:0] S_FETCH      = 4'd0;
   localparam logic [STEP_W-1:0] S_PUSH       = 4'd1;
   localparam logic [STEP_W-1:0] S_PUSH_WR    = 4'd2;
   localparam logic [STEP_W-1:0] S_SWAP       = 4'd3;
   localparam logic [STEP_W-1:0] S_SWAP_WR1   = 4'd4;
   localparam logic [STEP_W-1:0] S_SWAP_WR2   = 4'd5;
   localparam logic [STEP_W-1:0] S_ADD        = 4'd6;
   localparam logic [STEP_W-1:0] S_ADD_WR     = 4'd7;
   localparam logic [STEP_W-1:0] S_PRINT      = 4'd8;
   localparam logic [STEP_W-1:0] S_EMIT       = 4'd9;
   localparam logic [STEP_W-1:0] S_RSP_OK     = 4'd10;
   localparam logic [STEP_W-1:0] S_RSP_FULL   = 4'd11;
   localparam logic [STEP_W-1:0] S_RSP_SWAP_U = 4'd12;
   localparam logic [STEP_W-1:0] S_RSP_ADD_U  = 4'd13;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [COND_W-1:0]   cond;
      logic [STATUS_W-1:0] status;
      logic                wait_out;
      logic [STEP_W-1:0]   tgt_t;
      logic [STEP_W-1:0]   tgt_f;
   } ctrl_word_type;

   function automatic ctrl_word_type mk(input logic [OP_W-1:0] op,
                                        input logic [COND_W-1:0] cond,
                                        input logic [STATUS_W-1:0] status,
                                        input logic wait_out,
                                        input logic [STEP_W-1:0] tgt_t,
                                        input logic [STEP_W-1:0] tgt_f);
      ctrl_word_type w;
      w.op       = op;
      w.cond     = cond;
      w.status   = status;
      w.wait_out = wait_out;
      w.tgt_t    = tgt_t;
      w.tgt_f    = tgt_f;
      return w;
   endfunction

   function automatic ctrl_word_type micro_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      unique case (step)
         S_FETCH:      w = mk(OP_FETCH, C_DISPATCH, ST_OK, 1'b0, S_FETCH, S_FETCH);
         S_PUSH:       w = mk(OP_NONE, C_FULL, ST_OK, 1'b0, S_RSP_FULL, S_PUSH_WR);
         S_PUSH_WR:    w = mk(OP_PUSH, C_ALWAYS, ST_OK, 1'b0, S_RSP_OK, S_RSP_OK);
         S_SWAP:       w = mk(OP_READ2, C_LT2, ST_OK, 1'b0, S_RSP_SWAP_U, S_SWAP_WR1);
         S_SWAP_WR1:   w = mk(OP_SWAP_TOP, C_ALWAYS, ST_OK, 1'b0, S_SWAP_WR2, S_SWAP_WR2);
         S_SWAP_WR2:   w = mk(OP_SWAP_BELOW, C_ALWAYS, ST_OK, 1'b0, S_RSP_OK, S_RSP_OK);
         S_ADD:        w = mk(OP_READ2, C_LT2, ST_OK, 1'b0, S_RSP_ADD_U, S_ADD_WR);
         S_ADD_WR:     w = mk(OP_ADD, C_ALWAYS, ST_OK, 1'b0, S_RSP_OK, S_RSP_OK);
         S_PRINT:      w = mk(OP_PRINT_RD, C_EMPTY, ST_OK, 1'b0, S_RSP_OK, S_EMIT);
         S_EMIT:       w = mk(OP_EMIT, C_IDX_NZ, ST_OK, 1'b1, S_EMIT, S_FETCH);
         S_RSP_OK:     w = mk(OP_RESP, C_ALWAYS, ST_OK, 1'b1, S_FETCH, S_FETCH);
         S_RSP_FULL:   w = mk(OP_RESP, C_ALWAYS, ST_FULL, 1'b1, S_FETCH, S_FETCH);
         S_RSP_SWAP_U: w = mk(OP_RESP, C_ALWAYS, ST_SWAP_UNDER, 1'b1, S_FETCH, S_FETCH);
         S_RSP_ADD_U:  w = mk(OP_RESP, C_ALWAYS, ST_ADD_UNDER, 1'b1, S_FETCH, S_FETCH);
         default:      w = mk(OP_NONE, C_ALWAYS, ST_OK, 1'b0, S_FETCH, S_FETCH);
      endcase
      return w;
   endfunction

   // unused kind codes run as nop
   function automatic logic [STEP_W-1:0] dispatch(input logic [KIND_W-1:0] kind);
      logic [STEP_W-1:0] s;
      unique case (kind)
         K_PUSH:  s = S_PUSH;
         K_PRINT: s = S_PRINT;
         K_SWAP:  s = S_SWAP;
         K_ADD:   s = S_ADD;
         default: s = S_RSP_OK;
      endcase
      return s;
   endfunction

endpackage

// ===== design/stack_machine_push_swap_add.sv =====
// Bounded stack engine of 64 signed 32-bit entries, driven by a small microprogram held in a
// read-only table. One request is taken at a time. Push checks for a full stack and writes the
// new top; swap and add read the two top entries, then swap writes the top and the entry below
// in turn and add writes the sum below and pops. A full push or an underflowing swap or add
// answers with an error status. The stack memory has a single write port; a response that is
// not taken stalls the sequencer. Each request answers with one response, except print of a
// non-empty stack: one response per entry from top to bottom, the last marked by tlast; tuser
// flags a response that carries a printed entry. A request is taken while an earlier response
// still waits in the output register. The stack memory needs no clearing after reset.
module stack_machine_push_swap_add
   import smpsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // push_value[31:0]
   input  logic [KIND_W-1:0]     req_tuser,   // kind[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // status[1:0], entry_value[33:2], zero[39:34]
   output logic                  rsp_tuser,   // has_value
   output logic                  rsp_tlast    // last
);

   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [DATA_W-1:0]   rd_a_ff, rd_b_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                rsp_has_ff, rsp_has_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [DATA_W-1:0]   mem [STACK_DEPTH];

   ctrl_word_type       uw;
   logic                req_accept;
   logic                out_free;
   logic                hold;
   logic                cond_true;
   logic                run;
   logic [CNT_W-1:0]    count_m1, count_m2;
   logic [IDX_W-1:0]    top_idx, below_idx;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [DATA_W-1:0]   wr_data;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr_a;

   assign uw         = micro_rom(step_ff);
   assign req_tready = (step_ff == S_FETCH);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign hold       = (uw.wait_out && !out_free) || (uw.cond == C_DISPATCH && !req_accept);
   assign run        = !hold;

   assign count_m1  = count_ff - CNT_W'(1);
   assign count_m2  = count_ff - CNT_W'(2);
   assign top_idx   = count_m1[IDX_W-1:0];
   assign below_idx = count_m2[IDX_W-1:0];

   always_comb begin
      unique case (uw.cond)
         C_FULL:   cond_true = (count_ff >= CNT_W'(STACK_DEPTH));
         C_LT2:    cond_true = (count_ff < CNT_W'(2));
         C_EMPTY:  cond_true = (count_ff == '0);
         C_IDX_NZ: cond_true = (idx_ff != '0);
         default:  cond_true = 1'b1;
      endcase
   end

   always_comb begin
      if (hold) begin
         step_in = step_ff;
      end else if (uw.cond == C_DISPATCH) begin
         step_in = dispatch(req_tuser);
      end else if (cond_true) begin
         step_in = uw.tgt_t;
      end else begin
         step_in = uw.tgt_f;
      end
   end

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      wr_en         = 1'b0;
      wr_addr       = top_idx;
      wr_data       = rd_b_ff;
      rd_en         = 1'b0;
      rd_addr_a     = top_idx;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      if (run) begin
         unique case (uw.op)
            OP_FETCH: begin
               value_in = req_tdata;
            end
            OP_PUSH: begin
               wr_en    = 1'b1;
               wr_addr  = count_ff[IDX_W-1:0];
               wr_data  = value_ff;
               count_in = count_ff + CNT_W'(1);
            end
            OP_READ2: begin
               rd_en = !cond_true;
            end
            OP_SWAP_TOP: begin
               wr_en   = 1'b1;
               wr_addr = top_idx;
               wr_data = rd_b_ff;
            end
            OP_SWAP_BELOW: begin
               wr_en   = 1'b1;
               wr_addr = below_idx;
               wr_data = rd_a_ff;
            end
            OP_ADD: begin
               wr_en    = 1'b1;
               wr_addr  = below_idx;
               wr_data  = rd_a_ff + rd_b_ff;
               count_in = count_m1;
            end
            OP_PRINT_RD: begin
               rd_en  = !cond_true;
               idx_in = top_idx;
            end
            OP_EMIT: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = rd_a_ff;
               rsp_has_in    = 1'b1;
               rsp_last_in   = (idx_ff == '0);
               rd_en         = (idx_ff != '0);
               rd_addr_a     = idx_ff - IDX_W'(1);
               idx_in        = idx_ff - IDX_W'(1);
            end
            OP_RESP: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = uw.status;
               rsp_value_in  = '0;
               rsp_has_in    = 1'b0;
               rsp_last_in   = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[below_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= S_FETCH;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DATA_W - STATUS_W){1'b0}}, rsp_value_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_fetch_leaves: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> step_ff != S_FETCH)
      else $error("sequencer stayed in fetch after a request");

   a_only_print_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser && rsp_status_ff == ST_OK)
      else $error("non-final response that is not a printed entry");

   a_add_pops: assert property (@(posedge clock) disable iff (reset)
      step_ff == S_ADD_WR |=> count_ff + CNT_W'(1) == $past(count_ff))
      else $error("add did not pop one entry");

endmodule
